// ===== src/tmis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmis_pkg: shared types and constants for the tape machine step core
// Opcode and status codes, tape/stack geometry and stream field widths.
// ----------------------------------------------------------------------------
package tmis_pkg;

  // Geometry
  localparam int TAPE_CELLS     = 1024;
  localparam int PROG_ADDR_BITS = 12;
  localparam int LOOP_DEPTH     = 32;

  localparam int PTR_W  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int STK_AW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int SCNT_W = $clog2(LOOP_DEPTH + 1);

  // Field widths
  localparam int KIND_W   = 4;
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SKIP_W   = 6;

  localparam int IN_TDATA_W  = 24;  // addr + byte, padded to whole bytes
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1 + STATUS_W;

  localparam logic [SKIP_W-1:0] SKIP_MAX  = '1;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    ADDR_W'((64'd1 << PROG_ADDR_BITS) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    OP_RIGHT = 4'd0,
    OP_LEFT  = 4'd1,
    OP_INC   = 4'd2,
    OP_DEC   = 4'd3,
    OP_OPEN  = 4'd4,
    OP_CLOSE = 4'd5,
    OP_OUT   = 4'd6,
    OP_IN    = 4'd7,
    OP_NOP   = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_STACK_OVF = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_SKIP_OVF  = 2'd3
  } status_t;

endpackage

// ===== src/tmis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmis_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tape_machine_instruction_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_instruction_step_core: one tape-language opcode per request
// Pipeline registers: an accepted request enters the B stage, then its result the output register.
// Throughput: one request per cycle while the result channel is not stalled; the tape
//   and loop-stack RAMs are read at accept and written back, with a one-entry bypass for overlap.
// Reset: synchronous, active low. After reset the tape is swept to zero,
//   one cell per cycle (TAPE_CELLS = 1024 cells); in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module tape_machine_instruction_step_core
  import tmis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] prog_addr, [19:12] in_byte, [23:20] 0
  input  logic [KIND_W-1:0]      in_tuser,   // [3:0] kind
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] next_addr, [19:12] out_byte, [23:20] 0
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] out_valid, [2:1] status
);

  // --------------------------------------------------------------------------
  // Pipeline: accept -> execute (B) -> output register.
  // At accept the tape is read at the pointer the B stage leaves behind, and
  // the loop stack at the resulting top entry. B sees the registered read data;
  // if B wrote that same entry in the accept cycle, the bypass
  // register supplies the fresh value instead.
  // --------------------------------------------------------------------------

  // Tape clearing sweep
  logic             clearing_r, clearing_nxt;
  logic [PTR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Architectural state kept in flops
  logic [PTR_W-1:0]  dp_r, dp_nxt;
  logic [SCNT_W-1:0] sp_r, sp_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic              skipping_r, skipping_nxt;

  // B stage
  logic              b_valid_r, b_valid_nxt;
  kind_t             b_kind_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [BYTE_W-1:0] b_byte_r;
  logic              b_adv;
  logic              in_fire;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  // Tape RAM ports and bypass
  logic              tape_we;
  logic [PTR_W-1:0]  tape_waddr;
  logic [BYTE_W-1:0] tape_wdata;
  logic [BYTE_W-1:0] tape_rdata;
  logic              tape_fwd_r;
  logic [BYTE_W-1:0] tape_fwd_data_r;

  // Loop-stack RAM ports and bypass
  logic              stk_we;
  logic [ADDR_W-1:0] stk_rdata;
  logic [SCNT_W-1:0] stk_top_idx;
  logic [STK_AW-1:0] stk_raddr;
  logic              stk_fwd_r;
  logic [ADDR_W-1:0] stk_fwd_data_r;

  // Execute results
  logic              ex_tape_we;
  logic [BYTE_W-1:0] ex_tape_wdata;
  logic [BYTE_W-1:0] cur_cell;
  logic [ADDR_W-1:0] top;
  logic [ADDR_W-1:0] res_next;
  logic [BYTE_W-1:0] res_byte;
  logic              res_bvalid;
  status_t           res_status;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign b_adv     = !out_valid_r || out_tready;
  assign in_tready = !clearing_r && (!b_valid_r || b_adv);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Current operands with bypass
  assign cur_cell = tape_fwd_r ? tape_fwd_data_r : tape_rdata;
  assign top      = stk_fwd_r  ? stk_fwd_data_r  : stk_rdata;

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  always_comb begin
    dp_nxt        = dp_r;
    sp_nxt        = sp_r;
    skip_nxt      = skip_r;
    skipping_nxt  = skipping_r;
    ex_tape_we    = 1'b0;
    ex_tape_wdata = cur_cell;
    stk_we        = 1'b0;
    res_next      = (b_addr_r + ADDR_W'(1)) & ADDR_MASK;
    res_byte      = '0;
    res_bvalid    = 1'b0;
    res_status    = ST_OK;

    if (b_valid_r && b_adv) begin
      if (skipping_r) begin
        // passing over a loop body: only brackets count
        if (b_kind_r == OP_OPEN) begin
          if (skip_r == SKIP_MAX) begin
            res_status = ST_SKIP_OVF;
          end else begin
            skip_nxt = skip_r + SKIP_W'(1);
          end
        end else if (b_kind_r == OP_CLOSE) begin
          if (skip_r == '0) begin
            skipping_nxt = 1'b0;
          end else begin
            skip_nxt = skip_r - SKIP_W'(1);
          end
        end
      end else begin
        case (b_kind_r)
          OP_RIGHT: begin
            if (dp_r != PTR_W'(TAPE_CELLS - 1)) begin
              dp_nxt = dp_r + PTR_W'(1);
            end
          end
          OP_LEFT: begin
            if (dp_r != '0) begin
              dp_nxt = dp_r - PTR_W'(1);
            end
          end
          OP_INC: begin
            ex_tape_we    = 1'b1;
            ex_tape_wdata = cur_cell + BYTE_W'(1);
          end
          OP_DEC: begin
            ex_tape_we    = 1'b1;
            ex_tape_wdata = cur_cell - BYTE_W'(1);
          end
          OP_OPEN: begin
            if (cur_cell == '0) begin
              skipping_nxt = 1'b1;
              skip_nxt     = '0;
            end else if (sp_r >= SCNT_W'(LOOP_DEPTH)) begin
              res_status = ST_STACK_OVF;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SCNT_W'(1);
            end
          end
          OP_CLOSE: begin
            if (sp_r == '0) begin
              res_status = ST_UNMATCHED;
            end else if (cur_cell != '0) begin
              res_next = (top + ADDR_W'(1)) & ADDR_MASK;
            end else begin
              sp_nxt = sp_r - SCNT_W'(1);
            end
          end
          OP_OUT: begin
            res_byte   = cur_cell;
            res_bvalid = 1'b1;
          end
          OP_IN: begin
            ex_tape_we    = 1'b1;
            ex_tape_wdata = b_byte_r;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Tape write port: sweep after reset, execute writes after
  assign tape_we    = clearing_r || ex_tape_we;
  assign tape_waddr = clearing_r ? clr_addr_r : dp_r;
  assign tape_wdata = clearing_r ? '0 : ex_tape_wdata;

  // Stack read at the top left behind by this cycle's execute
  assign stk_top_idx = sp_nxt - SCNT_W'(1);
  assign stk_raddr   = stk_top_idx[STK_AW-1:0];

  tmis_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (dp_nxt),
    .rdata (tape_rdata)
  );

  tmis_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LOOP_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_r[STK_AW-1:0]),
    .wdata (b_addr_r & ADDR_MASK),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + PTR_W'(1);
      if (clr_addr_r == PTR_W'(TAPE_CELLS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end

    if (in_fire) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end else begin
      b_valid_nxt = b_valid_r;
    end

    if (b_valid_r && b_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      dp_r        <= '0;
      sp_r        <= '0;
      skip_r      <= '0;
      skipping_r  <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tape_fwd_r  <= 1'b0;
      stk_fwd_r   <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dp_r        <= dp_nxt;
      sp_r        <= sp_nxt;
      skip_r      <= skip_nxt;
      skipping_r  <= skipping_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tape_fwd_r  <= tape_we && (tape_waddr == dp_nxt);
      stk_fwd_r   <= stk_we && (sp_r[STK_AW-1:0] == stk_raddr);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    tape_fwd_data_r <= tape_wdata;
    stk_fwd_data_r  <= b_addr_r & ADDR_MASK;
    if (in_fire) begin
      b_kind_r <= kind_t'(in_tuser);
      b_addr_r <= in_tdata[ADDR_W-1:0];
      b_byte_r <= in_tdata[ADDR_W +: BYTE_W];
    end
    if (b_valid_r && b_adv) begin
      out_data_r <= {(OUT_TDATA_W - ADDR_W - BYTE_W)'(0), res_byte, res_next};
      out_user_r <= {res_status, res_bvalid};
    end
  end

endmodule

// ===== src/tmis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmis_checker: port-level checks for the tape machine step core
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module tmis_checker
  import tmis_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // Tape sweep follows reset: no request taken right after it
  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request accepted during tape sweep");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Output byte only on the output opcode, which never flags an error
  a_byte_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[19:12] == 8'd0)
    else $error("out byte nonzero without out_valid");

  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] != 2'd0 |-> !out_tuser[0])
    else $error("error status together with output byte");

endmodule

bind tape_machine_instruction_step_core tmis_checker u_tmis_checker (.*);
